### rtl/rlh_pkg.sv
package rlh_pkg;

  // Default sizes
  localparam int TABLE_ENTRIES_DEF  = 64;
  localparam int HISTOGRAM_BINS_DEF = 64;

  // Field widths
  localparam int KIND_W   = 2;
  localparam int KEY_W    = 64;
  localparam int TS_W     = 64;
  localparam int BINIDX_W = 6;
  localparam int STATUS_W = 3;
  localparam int BUCKET_W = 6;
  localparam int COUNT_W  = 32;
  localparam int WIDTH_W  = 32;

  localparam logic [WIDTH_W-1:0] BUCKET_WIDTH_RST = 32'd1000000;
  localparam logic [COUNT_W-1:0] COUNT_MAX        = '1;

  // Request kinds
  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DONE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_STORED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DROPPED   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_COUNTED   = 3'd2;
  localparam logic [STATUS_W-1:0] ST_UNMATCHED = 3'd3;
  localparam logic [STATUS_W-1:0] ST_READ      = 3'd4;

  // Controller states
  typedef enum logic [8:0] {
    S_CLR  = 9'b000000001,
    S_IDLE = 9'b000000010,
    S_SCAN = 9'b000000100,
    S_DCHK = 9'b000001000,
    S_DIV  = 9'b000010000,
    S_DFIN = 9'b000100000,
    S_BRD  = 9'b001000000,
    S_BUPD = 9'b010000000,
    S_OUT  = 9'b100000000
  } state_t;

endpackage

### rtl/request_latency_histogram.sv
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  kind, request_key, timestamp_ns, bin_index
// out_      output     out_valid/out_stall status, bucket, count
// cfg_      input      cfg_wr_en          cfg_wr_data (bucket_width_ns)
//
// One request at a time: a start or done walks the entry memory one entry per cycle and stops
// early on a hit; a counted done adds a range check, one quotient bit per cycle when in range
// and the bin update; a bin read reads its bin. After reset a clearing pass zeroes both
// memories with in_stall high. One result register decouples out_stall: the block goes back
// to idle as it loads the result and can take the next request while the last result still waits.
module request_latency_histogram #(
  parameter int TABLE_ENTRIES  = rlh_pkg::TABLE_ENTRIES_DEF,
  parameter int HISTOGRAM_BINS = rlh_pkg::HISTOGRAM_BINS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rlh_pkg::KIND_W-1:0]     in_kind,
  input  logic [rlh_pkg::KEY_W-1:0]      in_request_key,
  input  logic [rlh_pkg::TS_W-1:0]       in_timestamp_ns,
  input  logic [rlh_pkg::BINIDX_W-1:0]   in_bin_index,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rlh_pkg::STATUS_W-1:0]   out_status,
  output logic [rlh_pkg::BUCKET_W-1:0]   out_bucket,
  output logic [rlh_pkg::COUNT_W-1:0]    out_count,
  input  logic                           cfg_wr_en,
  input  logic [rlh_pkg::WIDTH_W-1:0]    cfg_wr_data
);

  localparam int TW    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int SCW   = $clog2(TABLE_ENTRIES + 1);
  localparam int BW    = $clog2(HISTOGRAM_BINS);
  localparam int CLR_N = (TABLE_ENTRIES > HISTOGRAM_BINS) ? TABLE_ENTRIES : HISTOGRAM_BINS;
  localparam int CW    = $clog2(CLR_N + 1);
  localparam int SW    = $clog2(BW + 1);
  localparam int EW    = 1 + rlh_pkg::KEY_W + rlh_pkg::TS_W;
  localparam int HW    = rlh_pkg::TS_W - BW;

  localparam logic [BW-1:0]  LAST_BIN = BW'(HISTOGRAM_BINS - 1);
  localparam logic [SCW-1:0] SCAN_END = SCW'(TABLE_ENTRIES);
  localparam logic [CW-1:0]  CLR_END  = CW'(CLR_N);
  localparam logic [CW-1:0]  CLR_ENT  = CW'(TABLE_ENTRIES);
  localparam logic [CW-1:0]  CLR_BIN  = CW'(HISTOGRAM_BINS);

  // Memories: entry word is {valid, key, start time}
  logic [EW-1:0]                   ent_mem [TABLE_ENTRIES];
  logic [rlh_pkg::COUNT_W-1:0]     bin_mem [HISTOGRAM_BINS];

  rlh_pkg::state_t                 state_r, state_nxt;
  logic [CW-1:0]                   clr_r, clr_nxt;
  logic [rlh_pkg::WIDTH_W-1:0]     width_r;

  logic [rlh_pkg::KIND_W-1:0]      kind_r, kind_nxt;
  logic [rlh_pkg::KEY_W-1:0]       key_r, key_nxt;
  logic [rlh_pkg::TS_W-1:0]        ts_r, ts_nxt;

  logic [SCW-1:0]                  scan_r, scan_nxt;
  logic [TW-1:0]                   cmp_idx_r;
  logic                            cmp_live_r, cmp_live_nxt;
  logic [TW-1:0]                   free_idx_r, free_idx_nxt;
  logic                            free_ok_r, free_ok_nxt;
  logic [EW-1:0]                   ent_rd_r;

  logic [rlh_pkg::TS_W-1:0]        delta_r, delta_nxt;
  logic [rlh_pkg::WIDTH_W-1:0]     rem_r, rem_nxt;
  logic [BW-1:0]                   dl_r, dl_nxt;
  logic [BW-1:0]                   quot_r, quot_nxt;
  logic [SW-1:0]                   step_r, step_nxt;
  logic [BW-1:0]                   bin_r, bin_nxt;
  logic [rlh_pkg::COUNT_W-1:0]     bin_rd_r;

  logic [rlh_pkg::STATUS_W-1:0]    res_status_r, res_status_nxt;
  logic [rlh_pkg::BUCKET_W-1:0]    res_bucket_r, res_bucket_nxt;
  logic [rlh_pkg::COUNT_W-1:0]     res_count_r, res_count_nxt;

  logic                            out_valid_r, out_valid_nxt;
  logic [rlh_pkg::STATUS_W-1:0]    out_status_r;
  logic [rlh_pkg::BUCKET_W-1:0]    out_bucket_r;
  logic [rlh_pkg::COUNT_W-1:0]     out_count_r;
  logic                            out_load;

  logic                            ent_we;
  logic [TW-1:0]                   ent_wa;
  logic [EW-1:0]                   ent_wd;
  logic                            bin_we;
  logic [BW-1:0]                   bin_wa;
  logic [rlh_pkg::COUNT_W-1:0]     bin_wd;

  logic                            accept;
  logic                            issuing;
  logic                            ent_vld;
  logic [rlh_pkg::KEY_W-1:0]       ent_key;
  logic [rlh_pkg::TS_W-1:0]        ent_ts;
  logic                            hit;
  logic [rlh_pkg::WIDTH_W:0]       trial;
  logic                            trial_ge;
  logic [7:0]                      bin_ext;
  logic [7:0]                      idx_ext;

  assign accept   = in_valid && (state_r == rlh_pkg::S_IDLE);
  assign in_stall = (state_r != rlh_pkg::S_IDLE);

  assign issuing  = (scan_r != SCAN_END);
  assign ent_vld  = ent_rd_r[EW-1];
  assign ent_key  = ent_rd_r[rlh_pkg::KEY_W+rlh_pkg::TS_W-1:rlh_pkg::TS_W];
  assign ent_ts   = ent_rd_r[rlh_pkg::TS_W-1:0];
  assign hit      = cmp_live_r && ent_vld && (ent_key == key_r);

  assign trial    = {rem_r, dl_r[BW-1]};
  assign trial_ge = (trial >= {1'b0, width_r});
  assign bin_ext  = 8'(bin_r);
  assign idx_ext  = 8'(in_bin_index);

  // Clear both memories after reset, then sequence one request through scan, divide, bin update and output
  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    ts_nxt         = ts_r;
    scan_nxt       = scan_r;
    cmp_live_nxt   = 1'b0;
    free_idx_nxt   = free_idx_r;
    free_ok_nxt    = free_ok_r;
    delta_nxt      = delta_r;
    rem_nxt        = rem_r;
    dl_nxt         = dl_r;
    quot_nxt       = quot_r;
    step_nxt       = step_r;
    bin_nxt        = bin_r;
    res_status_nxt = res_status_r;
    res_bucket_nxt = res_bucket_r;
    res_count_nxt  = res_count_r;
    out_load       = 1'b0;
    ent_we         = 1'b0;
    ent_wa         = cmp_idx_r;
    ent_wd         = '0;
    bin_we         = 1'b0;
    bin_wa         = bin_r;
    bin_wd         = '0;

    unique case (state_r)
      rlh_pkg::S_CLR: begin
        ent_we  = (clr_r < CLR_ENT);
        ent_wa  = clr_r[TW-1:0];
        bin_we  = (clr_r < CLR_BIN);
        bin_wa  = clr_r[BW-1:0];
        clr_nxt = clr_r + 1'b1;
        if (clr_nxt == CLR_END) begin
          state_nxt = rlh_pkg::S_IDLE;
        end
      end

      rlh_pkg::S_IDLE: begin
        if (accept) begin
          kind_nxt    = in_kind;
          key_nxt     = in_request_key;
          ts_nxt      = in_timestamp_ns;
          scan_nxt    = '0;
          free_ok_nxt = 1'b0;
          case (in_kind)
            rlh_pkg::KIND_START, rlh_pkg::KIND_DONE: begin
              state_nxt = rlh_pkg::S_SCAN;
            end
            rlh_pkg::KIND_READ: begin
              if (32'(in_bin_index) < HISTOGRAM_BINS) begin
                bin_nxt   = idx_ext[BW-1:0];
                state_nxt = rlh_pkg::S_BRD;
              end else begin
                res_status_nxt = rlh_pkg::ST_READ;
                res_bucket_nxt = in_bin_index;
                res_count_nxt  = '0;
                state_nxt      = rlh_pkg::S_OUT;
              end
            end
            default: begin
              // drop the unused kind without a result
              state_nxt = rlh_pkg::S_IDLE;
            end
          endcase
        end
      end

      rlh_pkg::S_SCAN: begin
        if (hit) begin
          ent_we = 1'b1;
          ent_wa = cmp_idx_r;
          if (kind_r == rlh_pkg::KIND_START) begin
            ent_wd         = {1'b1, key_r, ts_r};
            res_status_nxt = rlh_pkg::ST_STORED;
            res_bucket_nxt = '0;
            res_count_nxt  = '0;
            state_nxt      = rlh_pkg::S_OUT;
          end else begin
            ent_wd    = '0;
            delta_nxt = ts_r - ent_ts;
            state_nxt = rlh_pkg::S_DCHK;
          end
        end else begin
          // remember the lowest free slot
          if (cmp_live_r && !ent_vld && !free_ok_r) begin
            free_ok_nxt  = 1'b1;
            free_idx_nxt = cmp_idx_r;
          end
          if (issuing) begin
            scan_nxt     = scan_r + 1'b1;
            cmp_live_nxt = 1'b1;
          end else if (!cmp_live_r) begin
            res_bucket_nxt = '0;
            res_count_nxt  = '0;
            state_nxt      = rlh_pkg::S_OUT;
            if (kind_r == rlh_pkg::KIND_START) begin
              if (free_ok_r) begin
                ent_we         = 1'b1;
                ent_wa         = free_idx_r;
                ent_wd         = {1'b1, key_r, ts_r};
                res_status_nxt = rlh_pkg::ST_STORED;
              end else begin
                res_status_nxt = rlh_pkg::ST_DROPPED;
              end
            end else begin
              res_status_nxt = rlh_pkg::ST_UNMATCHED;
            end
          end
        end
      end

      rlh_pkg::S_DCHK: begin
        // quotient beyond the bin range goes straight to the last bin
        if (delta_r[rlh_pkg::TS_W-1:BW] >= HW'(width_r)) begin
          bin_nxt   = LAST_BIN;
          state_nxt = rlh_pkg::S_BRD;
        end else begin
          rem_nxt   = delta_r[BW+rlh_pkg::WIDTH_W-1:BW];
          dl_nxt    = delta_r[BW-1:0];
          quot_nxt  = '0;
          step_nxt  = SW'(BW);
          state_nxt = rlh_pkg::S_DIV;
        end
      end

      rlh_pkg::S_DIV: begin
        // one restoring step per cycle
        rem_nxt  = trial_ge ? rlh_pkg::WIDTH_W'(trial - {1'b0, width_r})
                            : trial[rlh_pkg::WIDTH_W-1:0];
        quot_nxt = (quot_r << 1) | BW'(trial_ge);
        dl_nxt   = dl_r << 1;
        step_nxt = step_r - 1'b1;
        if (step_r == SW'(1)) begin
          state_nxt = rlh_pkg::S_DFIN;
        end
      end

      rlh_pkg::S_DFIN: begin
        bin_nxt   = (quot_r >= LAST_BIN) ? LAST_BIN : quot_r;
        state_nxt = rlh_pkg::S_BRD;
      end

      rlh_pkg::S_BRD: begin
        state_nxt = rlh_pkg::S_BUPD;
      end

      rlh_pkg::S_BUPD: begin
        res_bucket_nxt = bin_ext[rlh_pkg::BUCKET_W-1:0];
        if (kind_r == rlh_pkg::KIND_READ) begin
          res_status_nxt = rlh_pkg::ST_READ;
          res_count_nxt  = bin_rd_r;
        end else begin
          bin_we         = 1'b1;
          bin_wa         = bin_r;
          bin_wd         = (bin_rd_r == rlh_pkg::COUNT_MAX) ? bin_rd_r : bin_rd_r + 1'b1;
          res_status_nxt = rlh_pkg::ST_COUNTED;
          res_count_nxt  = bin_wd;
        end
        state_nxt = rlh_pkg::S_OUT;
      end

      rlh_pkg::S_OUT: begin
        // hand over once the result register is free
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = rlh_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = rlh_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && out_stall);

  // Entry memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[ent_wa] <= ent_wd;
    end
    ent_rd_r <= ent_mem[scan_r[TW-1:0]];
  end

  // Histogram memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
    bin_rd_r <= bin_mem[bin_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rlh_pkg::S_CLR;
      clr_r       <= '0;
      cmp_live_r  <= 1'b0;
      out_valid_r <= 1'b0;
      width_r     <= rlh_pkg::BUCKET_WIDTH_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cmp_live_r  <= cmp_live_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        width_r <= cfg_wr_data;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    ts_r         <= ts_nxt;
    scan_r       <= scan_nxt;
    cmp_idx_r    <= scan_r[TW-1:0];
    free_idx_r   <= free_idx_nxt;
    free_ok_r    <= free_ok_nxt;
    delta_r      <= delta_nxt;
    rem_r        <= rem_nxt;
    dl_r         <= dl_nxt;
    quot_r       <= quot_nxt;
    step_r       <= step_nxt;
    bin_r        <= bin_nxt;
    res_status_r <= res_status_nxt;
    res_bucket_r <= res_bucket_nxt;
    res_count_r  <= res_count_nxt;
    if (out_load) begin
      out_status_r <= res_status_r;
      out_bucket_r <= res_bucket_r;
      out_count_r  <= res_count_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_bucket = out_bucket_r;
  assign out_count  = out_count_r;

endmodule

### tb/sv/request_latency_histogram_checker.sv
`timescale 1ns / 100ps

module request_latency_histogram_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [rlh_pkg::KIND_W-1:0]   in_kind,
  input  logic [rlh_pkg::KEY_W-1:0]    in_request_key,
  input  logic [rlh_pkg::TS_W-1:0]     in_timestamp_ns,
  input  logic [rlh_pkg::BINIDX_W-1:0] in_bin_index,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [rlh_pkg::STATUS_W-1:0] out_status,
  input  logic [rlh_pkg::BUCKET_W-1:0] out_bucket,
  input  logic [rlh_pkg::COUNT_W-1:0]  out_count,
  input  logic                         cfg_wr_en,
  input  logic [rlh_pkg::WIDTH_W-1:0]  cfg_wr_data,
  output int                           error_count,
  output int                           outstanding
);
  import rlh_pkg::*;

  localparam int ENTRIES = TABLE_ENTRIES_DEF;
  localparam int BINS    = HISTOGRAM_BINS_DEF;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [BUCKET_W-1:0] bucket;
    logic [COUNT_W-1:0]  count;
  } hist_result_t;

  // Shadow of the request table, the histogram and the bin width
  logic                slot_busy  [ENTRIES];
  logic [KEY_W-1:0]    slot_key   [ENTRIES];
  logic [TS_W-1:0]     slot_start [ENTRIES];
  logic [COUNT_W-1:0]  bin_total  [BINS];
  logic [WIDTH_W-1:0]  width_ns;

  hist_result_t expected_results[$];
  int           mismatches = 0;

  assign error_count = mismatches;

  function automatic int lookup_slot(input logic [KEY_W-1:0] key);
    for (int i = 0; i < ENTRIES; i++) begin
      if (slot_busy[i] && slot_key[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one request to the shadow state and queue the result it should produce
  task automatic predict_histogram_update(input logic [KIND_W-1:0]   kind,
                                          input logic [KEY_W-1:0]    key,
                                          input logic [TS_W-1:0]     now,
                                          input logic [BINIDX_W-1:0] idx);
    int           slot;
    int           bin;
    logic [TS_W-1:0] delta;
    logic [TS_W-1:0] quotient;
    hist_result_t res;
    res = '0;
    case (kind)
      KIND_START: begin
        slot = lookup_slot(key);
        for (int i = 0; i < ENTRIES && slot < 0; i++) begin
          if (!slot_busy[i]) slot = i;
        end
        if (slot < 0) begin
          res.status = ST_DROPPED;
        end else begin
          slot_busy[slot]  = 1'b1;
          slot_key[slot]   = key;
          slot_start[slot] = now;
          res.status       = ST_STORED;
        end
        expected_results.push_back(res);
      end
      KIND_DONE: begin
        slot = lookup_slot(key);
        if (slot < 0) begin
          res.status = ST_UNMATCHED;
        end else begin
          // wrapping difference, then clamp the quotient to the last bin
          delta = now - slot_start[slot];
          slot_busy[slot] = 1'b0;
          if (width_ns == '0) quotient = '1;
          else quotient = delta / {32'd0, width_ns};
          bin = (quotient >= 64'(BINS - 1)) ? BINS - 1 : int'(quotient);
          if (bin_total[bin] != COUNT_MAX) bin_total[bin] = bin_total[bin] + 1'b1;
          res.status = ST_COUNTED;
          res.bucket = BUCKET_W'(bin);
          res.count  = bin_total[bin];
        end
        expected_results.push_back(res);
      end
      KIND_READ: begin
        res.status = ST_READ;
        res.bucket = BUCKET_W'(idx);
        if (int'(idx) < BINS) res.count = bin_total[idx];
        expected_results.push_back(res);
      end
      default: begin
        // other kinds are dropped without a result
      end
    endcase
  endtask

  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", field, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    hist_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < ENTRIES; i++) begin
        slot_busy[i]  = 1'b0;
        slot_key[i]   = '0;
        slot_start[i] = '0;
      end
      for (int i = 0; i < BINS; i++) bin_total[i] = '0;
      width_ns = BUCKET_WIDTH_RST;
      expected_results.delete();
    end else begin
      // check a delivered result against the oldest prediction
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: status %0d bucket %0d count %0d",
                 out_status, out_bucket, out_count);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          compare_field("status", 64'(want.status), 64'(out_status));
          compare_field("bucket", 64'(want.bucket), 64'(out_bucket));
          compare_field("count", 64'(want.count), 64'(out_count));
        end
      end
      if (cfg_wr_en) width_ns = cfg_wr_data;
      if (in_valid && !in_stall) begin
        predict_histogram_update(in_kind, in_request_key, in_timestamp_ns, in_bin_index);
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### tb/sv/request_latency_histogram_test.sv
`timescale 1ns / 100ps

module request_latency_histogram_test;
  import rlh_pkg::*;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
  localparam int POOL_SIZE        = 96;
  localparam int RANDOM_PER_PHASE = 150;
  localparam int MIX_SPAN         = 60;
  // full table walk plus division, with margin
  localparam int SETTLE_CYCLES    = 100;
  localparam int CYCLE_LIMIT      = 1000000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [KIND_W-1:0]     in_kind;
  logic [KEY_W-1:0]      in_request_key;
  logic [TS_W-1:0]       in_timestamp_ns;
  logic [BINIDX_W-1:0]   in_bin_index;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   out_status;
  logic [BUCKET_W-1:0]   out_bucket;
  logic [COUNT_W-1:0]    out_count;
  logic                  cfg_wr_en;
  logic [WIDTH_W-1:0]    cfg_wr_data;

  int error_count;
  int outstanding;
  int cycle_count = 0;
  int burst_left  = 0;
  int stall_mode  = 0;
  int stall_left  = 0;

  logic [KEY_W-1:0]   pool_key [POOL_SIZE];
  logic [TS_W-1:0]    pool_ts  [POOL_SIZE];
  logic [WIDTH_W-1:0] cur_width;
  logic [WIDTH_W-1:0] width_plan [6];

  request_latency_histogram u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_request_key  (in_request_key),
    .in_timestamp_ns (in_timestamp_ns),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_bucket      (out_bucket),
    .out_count       (out_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  request_latency_histogram_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_request_key  (in_request_key),
    .in_timestamp_ns (in_timestamp_ns),
    .in_bin_index    (in_bin_index),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_bucket      (out_bucket),
    .out_count       (out_count),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .error_count     (error_count),
    .outstanding     (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Stall results in one of four randomly chosen modes, each held for a random stretch
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 7) != 0);
      default: out_stall <= ((stall_left % 4) < 2);
    endcase
  end

  // Drive one request, opening a new burst after a random gap when the last one ran out
  task automatic send_request(input logic [KIND_W-1:0]   kind,
                              input logic [KEY_W-1:0]    key,
                              input logic [TS_W-1:0]     ts,
                              input logic [BINIDX_W-1:0] idx);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      if ($urandom_range(0, 4) == 0) repeat ($urandom_range(20, 120)) @(posedge clk);
      else repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    in_valid        <= 1'b1;
    in_kind         <= kind;
    in_request_key  <= key;
    in_timestamp_ns <= ts;
    in_bin_index    <= idx;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    burst_left--;
  endtask

  // Drop valid, wait for every result, then let the block go quiet
  task automatic drain_and_settle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input logic [WIDTH_W-1:0] w);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= w;
    cur_width   = w;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Pick a completion time that lands in a random bin, or anywhere at all
  function automatic logic [TS_W-1:0] completion_time(input int pick);
    logic [TS_W-1:0] lat;
    if (cur_width == '0 || $urandom_range(0, 9) == 0) begin
      lat = {$urandom, $urandom};
    end else begin
      lat = 64'(cur_width) * 64'($urandom_range(0, 70))
          + 64'($urandom_range(0, cur_width - 1'b1));
    end
    return pool_ts[pick] + lat;
  endfunction

  // Issue one random request from the key pool; counted is low for ignored kinds
  task automatic random_request(input int start_pct, input int done_pct, output bit counted);
    int pick;
    int roll;
    pick    = $urandom_range(0, POOL_SIZE - 1);
    roll    = $urandom_range(0, 99);
    counted = 1'b1;
    if (roll < start_pct) begin
      pool_ts[pick] = {$urandom, $urandom};
      send_request(KIND_START, pool_key[pick], pool_ts[pick], BINIDX_W'($urandom));
    end else if (roll < start_pct + done_pct) begin
      send_request(KIND_DONE, pool_key[pick], completion_time(pick), BINIDX_W'($urandom));
    end else if (roll < 96) begin
      send_request(KIND_READ, {$urandom, $urandom}, {$urandom, $urandom}, BINIDX_W'($urandom));
    end else if (roll < 98) begin
      send_request(KIND_NONE, {$urandom, $urandom}, {$urandom, $urandom}, BINIDX_W'($urandom));
      counted = 1'b0;
    end else begin
      send_request(KIND_DONE, {$urandom, $urandom}, {$urandom, $urandom}, BINIDX_W'($urandom));
    end
  endtask

  initial begin
    int  issued;
    int  start_pct;
    int  done_pct;
    bit  counted;
    in_valid        <= 1'b0;
    in_kind         <= KIND_START;
    in_request_key  <= '0;
    in_timestamp_ns <= '0;
    in_bin_index    <= '0;
    cfg_wr_en       <= 1'b0;
    cfg_wr_data     <= '0;
    rst_n           <= 1'b0;
    cur_width       = BUCKET_WIDTH_RST;
    for (int i = 0; i < POOL_SIZE; i++) begin
      pool_key[i] = {$urandom, $urandom};
      pool_ts[i]  = '0;
    end
    pool_key[0] = '0;
    pool_key[1] = '1;
    width_plan[0] = BUCKET_WIDTH_RST;
    width_plan[1] = 32'd1;
    width_plan[2] = 32'd0;
    width_plan[3] = 32'hFFFF_FFFF;
    width_plan[4] = $urandom_range(2, 5000);
    width_plan[5] = $urandom;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed requests with ten nanoseconds per bin
    write_width(32'd10);
    send_request(KIND_READ, '0, '0, 6'd0);
    send_request(KIND_READ, '1, '1, 6'd63);
    send_request(KIND_START, '0, '0, 6'd0);
    send_request(KIND_DONE, '0, 64'd25, 6'd0);
    send_request(KIND_START, '1, '1, 6'd63);
    // completion before start wraps around
    send_request(KIND_DONE, '1, 64'd5, 6'd63);
    send_request(KIND_DONE, '0, '0, 6'd0);
    // restart of a live key overwrites its start time
    send_request(KIND_START, 64'hDEAD_BEEF_0123_4567, 64'd100, 6'd1);
    send_request(KIND_START, 64'hDEAD_BEEF_0123_4567, 64'd200, 6'd1);
    send_request(KIND_DONE, 64'hDEAD_BEEF_0123_4567, 64'd209, 6'd1);
    send_request(KIND_DONE, 64'hDEAD_BEEF_0123_4567, 64'd300, 6'd1);
    send_request(KIND_NONE, 64'h5555_AAAA_5555_AAAA, 64'hAAAA_5555_AAAA_5555, 6'h2A);
    send_request(KIND_START, 64'h8000_0000_0000_0001, '0, 6'h15);
    send_request(KIND_DONE, 64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000, 6'h15);
    // land on the bin below the last, on the last, and past it after wrap
    send_request(KIND_START, 64'h0000_0000_0000_00C0, 64'd1000, 6'd0);
    send_request(KIND_DONE, 64'h0000_0000_0000_00C0, 64'd1629, 6'd0);
    send_request(KIND_START, 64'h0000_0000_0000_00C1, 64'd0, 6'd0);
    send_request(KIND_DONE, 64'h0000_0000_0000_00C1, 64'd630, 6'd0);
    send_request(KIND_START, 64'h0000_0000_0000_00C2, 64'd500, 6'd0);
    send_request(KIND_DONE, 64'h0000_0000_0000_00C2, 64'd100, 6'd0);
    send_request(KIND_READ, '0, '0, 6'd2);
    send_request(KIND_READ, '0, '0, 6'd62);
    send_request(KIND_READ, '0, '0, 6'd63);
    send_request(KIND_READ, '0, '0, 6'h15);
    drain_and_settle();

    // Random phases, one per bin width; the request mix shifts between fill and drain
    for (int phase = 0; phase < 6; phase++) begin
      write_width(width_plan[phase]);
      issued    = 0;
      start_pct = 45;
      done_pct  = 45;
      while (issued < RANDOM_PER_PHASE) begin
        if (issued % MIX_SPAN == 0) begin
          case ($urandom_range(0, 2))
            0: begin start_pct = 80; done_pct = 15; end
            1: begin start_pct = 45; done_pct = 45; end
            default: begin start_pct = 15; done_pct = 75; end
          endcase
        end
        random_request(start_pct, done_pct, counted);
        if (counted) issued++;
      end
      drain_and_settle();
    end

    if (error_count == 0 && outstanding == 0) begin
      $display("request_latency_histogram_test passed");
    end else begin
      $display("request_latency_histogram_test failed");
    end
    $finish;
  end

  // Cycle limit for a stuck run
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("request_latency_histogram_test failed");
    $finish;
  end

endmodule
